/* rtl/core/assert_macros.svh */
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, off while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/rvx_pkg.sv */
package rvx_pkg;

  // major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load / store width codes
  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  // system funct3
  localparam logic [2:0] F3_PRIV   = 3'd0;
  localparam logic [2:0] F3_CSRRW  = 3'd1;
  localparam logic [2:0] F3_CSRRS  = 3'd2;
  localparam logic [2:0] F3_CSRRC  = 3'd3;
  localparam logic [2:0] F3_CSRRWI = 3'd5;
  localparam logic [2:0] F3_CSRRSI = 3'd6;
  localparam logic [2:0] F3_CSRRCI = 3'd7;

  localparam int unsigned CSR_ENTRIES = 4096;
  localparam int unsigned CSR_AW      = $clog2(CSR_ENTRIES);
  localparam logic [CSR_AW-1:0] CSR_ECALL  = 12'h000;
  localparam logic [CSR_AW-1:0] CSR_EBREAK = 12'h001;
  localparam logic [CSR_AW-1:0] CSR_MEPC   = 12'h341;
  localparam logic [CSR_AW-1:0] CSR_MIP    = 12'h344;

  typedef enum logic [2:0] {
    EV_RETIRED     = 3'd0,
    EV_LOAD_REQ    = 3'd1,
    EV_STORE       = 3'd2,
    EV_ECALL       = 3'd3,
    EV_EBREAK      = 3'd4,
    EV_BAD_OP      = 3'd5,
    EV_STORE_FAULT = 3'd6,
    EV_STRAY_LOAD  = 3'd7
  } event_t;

  typedef struct packed {
    logic [2:0] f3;
    logic       alt;   // SUB / SRA select
  } alu_ctrl_t;

endpackage

/* rtl/core/rvx_in_if.sv */
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] instruction;
  logic [31:0] load_data;

  modport source (output valid, kind, instruction, load_data, input ready);
  modport sink   (input valid, kind, instruction, load_data, output ready);
endinterface

/* rtl/core/rvx_out_if.sv */
interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] mem_address;
  logic [31:0] mem_data;
  logic [2:0]  access_bytes;
  logic [31:0] next_pc;

  modport source (output valid, event_res, mem_address, mem_data, access_bytes, next_pc,
                  input ready);
  modport sink   (input valid, event_res, mem_address, mem_data, access_bytes, next_pc,
                  output ready);
endinterface

/* rtl/core/rvx_alu.sv */
module rvx_alu (
  input  rvx_pkg::alu_ctrl_t ctrl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        y
);
  import rvx_pkg::*;

  logic [4:0] shamt;
  assign shamt = b[4:0];

  always_comb begin
    unique case (ctrl.f3)
      F3_ADD:  y = ctrl.alt ? (a - b) : (a + b);
      F3_SLL:  y = a << shamt;
      F3_SLT:  y = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: y = {31'd0, a < b};
      F3_XOR:  y = a ^ b;
      F3_SR:   y = ctrl.alt ? 32'($signed(a) >>> shamt) : (a >> shamt);
      F3_OR:   y = a | b;
      F3_AND:  y = a & b;
      default: y = a & b;
    endcase
  end
endmodule

/* rtl/core/rv32i_instruction_execute.sv */
// RV32I + Zicsr execute block, one beat in, one beat out.
// Path from input beat to result beat: operand read, then execute/writeback.
// Throughput: one beat per cycle unless out_ch stalls; the register file and CSR store
// are read at accept and a one-entry bypass covers the write made in that same cycle.
// Reset (rst_n, synchronous): control cleared, then a pass zeroes every entry of the
// CSR store, during which no input beat is accepted.
module rv32i_instruction_execute #(
  parameter longint unsigned MEM_BYTES = 65536
) (
  input  logic      clk,
  input  logic      rst_n,
  rvx_in_if.sink    in_ch,
  rvx_out_if.source out_ch
);
  import rvx_pkg::*;

  localparam logic [31:0] SP_RESET = 32'(MEM_BYTES - 4);
  localparam logic [31:0] GP_RESET = 32'(MEM_BYTES / 2);

  // reset contents of the register file (sp, fp at top of memory, gp mid-way)
  function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd2, 5'd8: v = SP_RESET;
      5'd3:       v = GP_RESET;
      default:    v = '0;
    endcase
    return v;
  endfunction

  // ---------------- CSR clearing pass after reset ----------------
  logic              clr_busy_r;
  logic [CSR_AW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + CSR_AW'(1);
      if (&clr_idx_r) clr_busy_r <= 1'b0;
    end
  end

  // ---------------- handshake ----------------
  logic ex_v_r, ex_adv, out_v_r, in_fire;

  assign ex_adv      = ex_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !clr_busy_r && (!ex_v_r || ex_adv);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // ---------------- storage ----------------
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;             // entry written since reset
  logic [31:0] csr_mem [CSR_ENTRIES];

  // operand read at accept
  logic [31:0]       rf_a_q, rf_b_q, csr_q;
  logic              rf_av_q, rf_bv_q;
  logic              ex_kind_r;
  logic [31:0]       ex_ins_r, ex_ld_r;

  // writeback from the execute stage
  logic              rf_we, csr_we;
  logic [4:0]        rf_wa;
  logic [31:0]       rf_wd, csr_wd;
  logic [CSR_AW-1:0] csr_wa;

  // last write, covers a read made at the same edge
  logic              rf_byp_v_r, csr_byp_v_r;
  logic [4:0]        rf_byp_idx_r;
  logic [31:0]       rf_byp_dat_r, csr_byp_dat_r;
  logic [CSR_AW-1:0] csr_byp_idx_r;

  // architectural state
  logic [31:0] pc_r, pc_nxt, mepc_r;
  logic        ld_pend_r, ld_pend_nxt;
  logic [4:0]  ld_dest_r, ld_dest_nxt;
  logic [2:0]  ld_wc_r, ld_wc_nxt;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rf_a_q    <= rf_mem[in_ch.instruction[19:15]];
      rf_b_q    <= rf_mem[in_ch.instruction[24:20]];
      rf_av_q   <= rf_vld_r[in_ch.instruction[19:15]];
      rf_bv_q   <= rf_vld_r[in_ch.instruction[24:20]];
      ex_kind_r <= in_ch.kind;
      ex_ins_r  <= in_ch.instruction;
      ex_ld_r   <= in_ch.load_data;
    end
    if (ex_adv && rf_we) rf_mem[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (in_fire) csr_q <= csr_mem[in_ch.instruction[31:20]];
    if (clr_busy_r)               csr_mem[clr_idx_r] <= '0;
    else if (ex_adv && csr_we)    csr_mem[csr_wa]    <= csr_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r       <= 1'b0;
      rf_vld_r     <= '0;
      rf_byp_v_r   <= 1'b0;
      csr_byp_v_r  <= 1'b0;
      pc_r         <= '0;
      mepc_r       <= '0;
      ld_pend_r    <= 1'b0;
      ld_dest_r    <= '0;
      ld_wc_r      <= '0;
    end else begin
      if (in_fire)     ex_v_r <= 1'b1;
      else if (ex_adv) ex_v_r <= 1'b0;
      if (ex_adv) begin
        pc_r      <= pc_nxt;
        ld_pend_r <= ld_pend_nxt;
        ld_dest_r <= ld_dest_nxt;
        ld_wc_r   <= ld_wc_nxt;
        if (rf_we) begin
          rf_vld_r[rf_wa] <= 1'b1;
          rf_byp_v_r      <= 1'b1;
        end
        if (csr_we) begin
          csr_byp_v_r <= 1'b1;
          if (csr_wa == CSR_MEPC) mepc_r <= csr_wd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv && rf_we) begin
      rf_byp_idx_r <= rf_wa;
      rf_byp_dat_r <= rf_wd;
    end
    if (ex_adv && csr_we) begin
      csr_byp_idx_r <= csr_wa;
      csr_byp_dat_r <= csr_wd;
    end
  end

  // ---------------- execute ----------------
  logic [6:0]        op;
  logic [4:0]        rd, rs1, rs2, zimm;
  logic [2:0]        f3;
  logic [CSR_AW-1:0] csr_idx;
  logic [31:0]       rs1v, rs2v, csr_old, imm_i, imm_s, imm_b, imm_j, pc_plus4;
  logic [31:0]       ea_ld, ea_st, csr_src;
  logic [31:0]       alu_y;
  alu_ctrl_t         alu_ctrl;
  logic [31:0]       alu_b;
  logic              take;

  assign op      = ex_ins_r[6:0];
  assign rd      = ex_ins_r[11:7];
  assign f3      = ex_ins_r[14:12];
  assign rs1     = ex_ins_r[19:15];
  assign rs2     = ex_ins_r[24:20];
  assign zimm    = ex_ins_r[19:15];
  assign csr_idx = ex_ins_r[31:20];

  assign rs1v = (rf_byp_v_r && rf_byp_idx_r == rs1) ? rf_byp_dat_r :
                (rf_av_q ? rf_a_q : rf_reset_val(rs1));
  assign rs2v = (rf_byp_v_r && rf_byp_idx_r == rs2) ? rf_byp_dat_r :
                (rf_bv_q ? rf_b_q : rf_reset_val(rs2));
  assign csr_old = (csr_byp_v_r && csr_byp_idx_r == csr_idx) ? csr_byp_dat_r : csr_q;

  assign imm_i = {{20{ex_ins_r[31]}}, ex_ins_r[31:20]};
  assign imm_s = {{20{ex_ins_r[31]}}, ex_ins_r[31:25], ex_ins_r[11:7]};
  assign imm_b = {{19{ex_ins_r[31]}}, ex_ins_r[31], ex_ins_r[7], ex_ins_r[30:25],
                  ex_ins_r[11:8], 1'b0};
  assign imm_j = {{11{ex_ins_r[31]}}, ex_ins_r[31], ex_ins_r[19:12], ex_ins_r[20],
                  ex_ins_r[30:21], 1'b0};
  assign pc_plus4 = pc_r + 32'd4;
  assign ea_ld    = rs1v + imm_i;
  assign ea_st    = rs1v + imm_s;
  assign csr_src  = f3[2] ? {27'd0, zimm} : rs1v;

  // register form: any funct7 selects SUB/SRA; immediate form: SRAI only
  always_comb begin
    alu_ctrl.f3  = f3;
    alu_ctrl.alt = (op == OP_REG) ? (ex_ins_r[31:25] != 7'd0)
                                  : (f3 == F3_SR && ex_ins_r[31:25] != 7'd0);
    alu_b        = (op == OP_REG) ? rs2v : imm_i;
  end

  rvx_alu u_alu (.ctrl(alu_ctrl), .a(rs1v), .b(alu_b), .y(alu_y));

  always_comb begin
    case (f3)
      F3_BEQ:  take = rs1v == rs2v;
      F3_BNE:  take = rs1v != rs2v;
      F3_BLT:  take = $signed(rs1v) < $signed(rs2v);
      F3_BGE:  take = $signed(rs1v) >= $signed(rs2v);
      F3_BLTU: take = rs1v < rs2v;
      F3_BGEU: take = rs1v >= rs2v;
      default: take = 1'b0;
    endcase
  end

  event_t      ev;
  logic [31:0] addr, data;
  logic [2:0]  nbytes;

  always_comb begin
    ev          = EV_RETIRED;
    addr        = '0;
    data        = '0;
    nbytes      = '0;
    pc_nxt      = pc_r;
    rf_we       = 1'b0;
    rf_wa       = rd;
    rf_wd       = '0;
    csr_we      = 1'b0;
    csr_wa      = csr_idx;
    csr_wd      = '0;
    ld_pend_nxt = 1'b0;
    ld_dest_nxt = ld_dest_r;
    ld_wc_nxt   = ld_wc_r;

    if (ex_kind_r) begin
      if (!ld_pend_r) begin
        ev = EV_STRAY_LOAD;
      end else begin
        rf_we = 1'b1;
        rf_wa = ld_dest_r;
        case (ld_wc_r)
          F3_B:    rf_wd = {{24{ex_ld_r[7]}}, ex_ld_r[7:0]};
          F3_H:    rf_wd = {{16{ex_ld_r[15]}}, ex_ld_r[15:0]};
          F3_BU:   rf_wd = {24'd0, ex_ld_r[7:0]};
          F3_HU:   rf_wd = {16'd0, ex_ld_r[15:0]};
          default: rf_wd = ex_ld_r;
        endcase
      end
    end else begin
      pc_nxt = pc_plus4;
      unique case (op)
        OP_REG, OP_IMM: begin
          rf_we = 1'b1;
          rf_wd = alu_y;
        end
        OP_LUI: begin
          rf_we = 1'b1;
          rf_wd = {ex_ins_r[31:12], 12'd0};
        end
        OP_AUIPC: begin
          rf_we = 1'b1;
          rf_wd = {ex_ins_r[31:12], 12'd0} + pc_r;
        end
        OP_JAL: begin
          rf_we  = 1'b1;
          rf_wd  = pc_plus4;
          pc_nxt = pc_r + imm_j;
        end
        OP_JALR: begin
          rf_we  = 1'b1;
          rf_wd  = pc_plus4;
          pc_nxt = {ea_ld[31:1], 1'b0};
        end
        OP_BRANCH: begin
          if (take) pc_nxt = pc_r + imm_b;
        end
        OP_LOAD: begin
          // negative address or reserved width: retires with no request
          if (!ea_ld[31] && f3 != 3'd3 && f3 < 3'd6) begin
            ev          = EV_LOAD_REQ;
            addr        = ea_ld;
            nbytes      = (f3[1:0] == 2'd0) ? 3'd1 : ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
            ld_pend_nxt = 1'b1;
            ld_dest_nxt = rd;
            ld_wc_nxt   = f3;
          end
        end
        OP_STORE: begin
          if (ea_st[31]) begin
            ev     = EV_STORE_FAULT;
            addr   = ea_st;
            pc_nxt = pc_r;
          end else if (f3 < 3'd3) begin
            ev   = EV_STORE;
            addr = ea_st;
            case (f3)
              F3_B:    begin nbytes = 3'd1; data = {24'd0, rs2v[7:0]};  end
              F3_H:    begin nbytes = 3'd2; data = {16'd0, rs2v[15:0]}; end
              default: begin nbytes = 3'd4; data = rs2v;                end
            endcase
          end
        end
        OP_SYSTEM: begin
          unique case (f3)
            F3_PRIV: begin
              if (csr_idx == CSR_ECALL) begin
                ev     = EV_ECALL;
                pc_nxt = pc_r;
              end else if (csr_idx == CSR_EBREAK) begin
                ev     = EV_EBREAK;
                pc_nxt = pc_r;
              end else begin
                // MRET: resume at MEPC, clear MIP
                pc_nxt = mepc_r;
                csr_we = 1'b1;
                csr_wa = CSR_MIP;
                csr_wd = '0;
              end
            end
            F3_CSRRW, F3_CSRRWI: begin
              csr_we = 1'b1;
              csr_wd = csr_src;
              rf_we  = 1'b1;
              rf_wd  = csr_old;
            end
            F3_CSRRS, F3_CSRRSI: begin
              csr_we = 1'b1;
              csr_wd = csr_old | csr_src;
              rf_we  = 1'b1;
              rf_wd  = csr_old;
            end
            F3_CSRRC, F3_CSRRCI: begin
              csr_we = 1'b1;
              csr_wd = csr_old & ~csr_src;
              rf_we  = 1'b1;
              rf_wd  = csr_old;
            end
            default: ;
          endcase
        end
        default: begin
          ev     = EV_BAD_OP;
          pc_nxt = pc_r;
        end
      endcase
    end
    // x0 is never written
    if (rf_wa == 5'd0) rf_we = 1'b0;
  end

  // ---------------- result register ----------------
  event_t      out_ev_r;
  logic [31:0] out_addr_r, out_data_r, out_npc_r;
  logic [2:0]  out_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ex_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      out_ev_r    <= ev;
      out_addr_r  <= addr;
      out_data_r  <= data;
      out_bytes_r <= nbytes;
      out_npc_r   <= pc_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.event_res    = out_ev_r;
  assign out_ch.mem_address  = out_addr_r;
  assign out_ch.mem_data     = out_data_r;
  assign out_ch.access_bytes = out_bytes_r;
  assign out_ch.next_pc      = out_npc_r;

endmodule

/* rtl/core/rvx_checker.sv */
`include "assert_macros.svh"
module rvx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic [31:0] mem_address,
  input logic [2:0]  access_bytes
);
  import rvx_pkg::*;

  `ASSERT_NEXT_ALWAYS(a_rst_no_beat, clk, !rst_n, !out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_no_access, clk, rst_n, out_valid && (event_res == EV_RETIRED || event_res == EV_ECALL || event_res == EV_EBREAK || event_res == EV_BAD_OP || event_res == EV_STRAY_LOAD || event_res == EV_STORE_FAULT), access_bytes == 3'd0)
  `ASSERT_IMPL(a_access_ok, clk, rst_n, out_valid && (event_res == EV_LOAD_REQ || event_res == EV_STORE), !mem_address[31] && (access_bytes == 3'd1 || access_bytes == 3'd2 || access_bytes == 3'd4))
  `ASSERT_IMPL(a_fault_neg, clk, rst_n, out_valid && event_res == EV_STORE_FAULT, mem_address[31])

endmodule

bind rv32i_instruction_execute rvx_checker u_rvx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .mem_address  (out_ch.mem_address),
  .access_bytes (out_ch.access_bytes)
);
